/* rtl/mst_pkg.sv */
// mst_pkg: shared types and codes for the message slot table
// no dependencies
package mst_pkg;

   localparam logic [3:0] OP_ADD_IN   = 4'd0;
   localparam logic [3:0] OP_QUEUE    = 4'd1;
   localparam logic [3:0] OP_SET      = 4'd2;
   localparam logic [3:0] OP_MARK     = 4'd3;
   localparam logic [3:0] OP_READ     = 4'd4;
   localparam logic [3:0] OP_TICK     = 4'd5;
   localparam logic [3:0] OP_PENDING  = 4'd6;
   localparam logic [3:0] OP_PURGE    = 4'd7;
   localparam logic [3:0] OP_CLEAR    = 4'd8;

   localparam logic [2:0] ST_EXPIRED   = 3'd0;
   localparam logic [2:0] ST_QUEUED    = 3'd1;
   localparam logic [2:0] ST_SENDING   = 3'd2;
   localparam logic [2:0] ST_DELIVERED = 3'd3;
   localparam logic [2:0] ST_FAILED    = 3'd4;

   localparam logic [1:0] RS_OK   = 2'd0;
   localparam logic [1:0] RS_DUP  = 2'd1;
   localparam logic [1:0] RS_NONE = 2'd2;

   localparam logic [1:0] CSR_EXPIRE = 2'd0;
   localparam logic [1:0] CSR_RETRY  = 2'd1;
   localparam logic [1:0] CSR_BURN   = 2'd2;

   // one table entry as stored in the memory
   typedef struct packed {
      logic [31:0] id;
      logic [31:0] sender;
      logic [31:0] dest;
      logic [31:0] stamp;
      logic [31:0] expiry;
      logic [7:0]  flags;
      logic        rd;
      logic        inc;
      logic [2:0]  st;
   } entry_type;

endpackage

/* rtl/message_slot_table_with_aging.sv */
// Message table of SLOTS entries held in one synchronous memory, one operation at a time.
// Add scans for duplicates and an eviction slot; tick, purge and the unread recount each
// sweep the occupied entries through the single read port one address a cycle, and clear
// and purge zero the freed entries one a cycle. The input channel is not ready while an
// operation is in flight or its result waits. After reset a clearing pass zeroes every
// slot before the first item is taken.
// depends on mst_pkg, mst_mem
module message_slot_table_with_aging #(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_operation,
   input  logic [31:0] req_now_ms,
   input  logic [31:0] req_peer_id,
   input  logic [31:0] req_message_id,
   input  logic [7:0]  req_message_flags,
   input  logic [3:0]  req_slot_index,
   input  logic [2:0]  req_new_state,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_result_slot,
   output logic [31:0] rsp_entry_msg_id,
   output logic [31:0] rsp_entry_sender,
   output logic [31:0] rsp_entry_dest,
   output logic [2:0]  rsp_entry_state,
   output logic [7:0]  rsp_entry_flags,
   output logic        rsp_entry_incoming,
   output logic        rsp_entry_read,
   output logic [4:0]  rsp_used_count,
   output logic [4:0]  rsp_unread_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   // sequencer states
   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_SCAN   = 4'd2;
   localparam logic [3:0] S_SCANW  = 4'd3;
   localparam logic [3:0] S_PICK   = 4'd4;
   localparam logic [3:0] S_WRITE  = 4'd5;
   localparam logic [3:0] S_PURGE  = 4'd6;
   localparam logic [3:0] S_WIPE   = 4'd7;
   localparam logic [3:0] S_COUNT  = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;
   localparam logic [3:0] S_RSP    = 4'd10;
   localparam logic [3:0] S_SINGLE = 4'd11;

   logic [3:0]  state_ff, state_in;
   logic [CW-1:0] ptr_ff, ptr_in;     // address being read
   logic [CW-1:0] wp_ff, wp_in;       // purge write pointer
   logic        pend_ff, pend_in;     // read data valid this cycle
   logic [AW-1:0] pidx_ff, pidx_in;   // address of data in flight
   logic [CW-1:0] occ_ff, occ_in;
   logic [31:0] serial_ff, serial_in;
   logic [31:0] expire_ff;
   logic [7:0]  retry_ff, burn_ff;
   logic [4:0]  unread_ff, unread_in;
   logic        found_ff, found_in;
   logic [AW-1:0] best_ff, best_in;
   logic [31:0] best_ts_ff, best_ts_in;
   logic        exp_found_ff, exp_found_in;

   // latched request
   logic [3:0]  op_ff;
   logic [31:0] now_ff, peer_ff, mid_ff;
   logic [7:0]  fl_ff;
   logic [3:0]  idx_ff;
   logic [2:0]  ns_ff;

   // result register
   logic [1:0]  r_status_ff, r_status_in;
   logic [3:0]  r_slot_ff, r_slot_in;
   mst_pkg::entry_type r_ent_ff, r_ent_in;

   logic        wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   mst_pkg::entry_type wr_data, rd_data, cur;

   mst_mem #(.SLOTS(SLOTS), .AW(AW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign cur = rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         expire_ff <= 32'd300000;
         retry_ff  <= 8'd3;
         burn_ff   <= 8'd1;
      end else if (csr_valid) begin
         case (csr_index)
            mst_pkg::CSR_EXPIRE: expire_ff <= csr_data;
            mst_pkg::CSR_RETRY:  retry_ff  <= csr_data[7:0];
            mst_pkg::CSR_BURN:   burn_ff   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // request latch
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff  <= req_operation;
         now_ff <= req_now_ms;
         peer_ff <= req_peer_id;
         mid_ff <= req_message_id;
         fl_ff  <= req_message_flags;
         idx_ff <= req_slot_index;
         ns_ff  <= req_new_state;
      end
   end

   logic last_rd;
   logic cur_unread;
   logic [2:0] tick_st;
   mst_pkg::entry_type new_ent;

   // new entry for add and queue
   always_comb begin
      new_ent = '0;
      new_ent.stamp  = now_ff;
      new_ent.expiry = now_ff + expire_ff;
      new_ent.flags  = fl_ff;
      if (op_ff == mst_pkg::OP_ADD_IN) begin
         new_ent.id = mid_ff;
         new_ent.sender = peer_ff;
         new_ent.st = mst_pkg::ST_DELIVERED;
         new_ent.inc = 1'b1;
      end else begin
         new_ent.id = serial_ff + 32'd1;
         new_ent.dest = peer_ff;
         new_ent.st = mst_pkg::ST_QUEUED;
         new_ent.rd = 1'b1;
      end
   end

   // aging rule for one entry
   always_comb begin
      tick_st = cur.st;
      if (cur.st != mst_pkg::ST_EXPIRED) begin
         if (now_ff > cur.expiry) tick_st = mst_pkg::ST_EXPIRED;
         else if (((cur.flags & burn_ff) != 8'd0) && cur.rd && cur.inc)
            tick_st = mst_pkg::ST_EXPIRED;
         else if (!cur.inc && cur.st == mst_pkg::ST_QUEUED)
            tick_st = (retry_ff != 8'd0) ? mst_pkg::ST_SENDING : mst_pkg::ST_FAILED;
      end
   end

   assign cur_unread = cur.inc && !cur.rd && (cur.st != mst_pkg::ST_EXPIRED);

   // sequencer
   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff;
      wp_in = wp_ff;
      pend_in = 1'b0;
      pidx_in = pidx_ff;
      occ_in = occ_ff;
      serial_in = serial_ff;
      unread_in = unread_ff;
      found_in = found_ff;
      best_in = best_ff;
      best_ts_in = best_ts_ff;
      exp_found_in = exp_found_ff;
      r_status_in = r_status_ff;
      r_slot_in = r_slot_ff;
      r_ent_in = r_ent_ff;
      wr_en = 1'b0;
      wr_addr = pidx_ff;
      wr_data = cur;
      rd_addr = ptr_ff[AW-1:0];
      last_rd = (ptr_ff + CW'(1) >= occ_ff);
      case (state_ff)
         S_INIT: begin
            wr_en = 1'b1;
            wr_addr = ptr_ff[AW-1:0];
            wr_data = '0;
            ptr_in = ptr_ff + CW'(1);
            if (ptr_ff == CW'(SLOTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               ptr_in = '0;
               wp_in = '0;
               found_in = 1'b0;
               exp_found_in = 1'b0;
               best_in = '0;
               best_ts_in = 32'hFFFFFFFF;
               r_status_in = mst_pkg::RS_OK;
               r_slot_in = '0;
               r_ent_in = '0;
               case (req_operation)
                  mst_pkg::OP_ADD_IN, mst_pkg::OP_QUEUE, mst_pkg::OP_TICK,
                  mst_pkg::OP_PENDING, mst_pkg::OP_PURGE:
                     state_in = S_SCAN;
                  mst_pkg::OP_SET, mst_pkg::OP_MARK, mst_pkg::OP_READ: begin
                     if (CW'(req_slot_index) >= occ_ff || 32'(req_slot_index) >= SLOTS
                         || (req_operation == mst_pkg::OP_SET
                             && req_new_state > mst_pkg::ST_FAILED)) begin
                        r_status_in = mst_pkg::RS_NONE;
                        state_in = S_COUNT;
                     end else begin
                        ptr_in = CW'(req_slot_index);
                        state_in = S_SINGLE;
                     end
                  end
                  mst_pkg::OP_CLEAR: begin
                     occ_in = '0;
                     state_in = S_WIPE;
                  end
                  default: state_in = S_COUNT;
               endcase
            end
         end
         S_SINGLE: begin
            // issue read of addressed slot
            pend_in = 1'b1;
            pidx_in = ptr_ff[AW-1:0];
            state_in = S_SCANW;
         end
         S_SCAN: begin
            // stream reads of slots, process each slot's data in the cycle after its read
            if (pend_ff) begin
               case (op_ff)
                  mst_pkg::OP_ADD_IN, mst_pkg::OP_QUEUE: begin
                     if (op_ff == mst_pkg::OP_ADD_IN && cur.id == mid_ff
                         && cur.sender == peer_ff) found_in = 1'b1;
                     if (!exp_found_ff) begin
                        if (cur.st == mst_pkg::ST_EXPIRED) begin
                           exp_found_in = 1'b1;
                           best_in = pidx_ff;
                        end else if (cur.stamp < best_ts_ff) begin
                           best_ts_in = cur.stamp;
                           best_in = pidx_ff;
                        end
                     end
                  end
                  mst_pkg::OP_TICK: begin
                     wr_en = 1'b1;
                     wr_data = cur;
                     wr_data.st = tick_st;
                  end
                  mst_pkg::OP_PENDING: begin
                     if (!found_ff && !cur.inc && cur.st == mst_pkg::ST_SENDING) begin
                        found_in = 1'b1;
                        r_slot_in = 4'(pidx_ff);
                        r_ent_in = cur;
                     end
                  end
                  mst_pkg::OP_PURGE: begin
                     if (cur.st != mst_pkg::ST_EXPIRED) begin
                        wr_en = 1'b1;
                        wr_addr = wp_ff[AW-1:0];
                        wp_in = wp_ff + CW'(1);
                     end
                  end
                  default: ;
               endcase
            end
            if (ptr_ff < occ_ff && !pend_ff) begin
               // first read
               pend_in = 1'b1;
               pidx_in = ptr_ff[AW-1:0];
               ptr_in = ptr_ff + CW'(1);
            end else if (pend_ff && ptr_ff < occ_ff) begin
               pend_in = 1'b1;
               pidx_in = ptr_ff[AW-1:0];
               ptr_in = ptr_ff + CW'(1);
            end else if (!pend_ff || !last_rd || ptr_ff >= occ_ff) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            case (op_ff)
               mst_pkg::OP_ADD_IN, mst_pkg::OP_QUEUE: begin
                  if (found_ff) begin
                     r_status_in = mst_pkg::RS_DUP;
                     state_in = S_COUNT;
                  end else begin
                     if (occ_ff < CW'(SLOTS)) begin
                        pidx_in = occ_ff[AW-1:0];
                        occ_in = occ_ff + CW'(1);
                     end else begin
                        pidx_in = best_ff;
                     end
                     state_in = S_WRITE;
                  end
               end
               mst_pkg::OP_PENDING: begin
                  if (!found_ff) r_status_in = mst_pkg::RS_NONE;
                  state_in = S_COUNT;
               end
               mst_pkg::OP_PURGE: begin
                  occ_in = wp_ff;
                  ptr_in = wp_ff;
                  state_in = S_WIPE;
               end
               default: state_in = S_COUNT;
            endcase
         end
         S_WRITE: begin
            wr_en = 1'b1;
            wr_addr = pidx_ff;
            wr_data = new_ent;
            if (op_ff == mst_pkg::OP_QUEUE) serial_in = serial_ff + 32'd1;
            r_slot_in = 4'(pidx_ff);
            r_ent_in = new_ent;
            state_in = S_COUNT;
         end
         S_SCANW: begin
            // single slot modify
            wr_en = 1'b1;
            wr_data = cur;
            if (op_ff == mst_pkg::OP_SET) wr_data.st = ns_ff;
            else if (op_ff == mst_pkg::OP_MARK) wr_data.rd = 1'b1;
            r_slot_in = 4'(pidx_ff);
            r_ent_in = wr_data;
            state_in = S_COUNT;
         end
         S_WIPE: begin
            if (ptr_ff < CW'(SLOTS)) begin
               wr_en = 1'b1;
               wr_addr = ptr_ff[AW-1:0];
               wr_data = '0;
               ptr_in = ptr_ff + CW'(1);
            end else begin
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            ptr_in = '0;
            unread_in = '0;
            state_in = S_DONE;
         end
         S_DONE: begin
            // recount unread entries, pipelined behind the registered read
            if (pend_ff && cur_unread) unread_in = unread_ff + 5'd1;
            if (ptr_ff < occ_ff) begin
               pend_in = 1'b1;
               ptr_in = ptr_ff + CW'(1);
            end else if (!pend_ff) begin
               state_in = S_RSP;
            end
         end
         S_RSP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         ptr_ff <= '0;
         pend_ff <= 1'b0;
         occ_ff <= '0;
         serial_ff <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff <= ptr_in;
         pend_ff <= pend_in;
         occ_ff <= occ_in;
         serial_ff <= serial_in;
      end
      wp_ff <= wp_in;
      pidx_ff <= pidx_in;
      unread_ff <= unread_in;
      found_ff <= found_in;
      best_ff <= best_in;
      best_ts_ff <= best_ts_in;
      exp_found_ff <= exp_found_in;
      r_status_ff <= r_status_in;
      r_slot_ff <= r_slot_in;
      r_ent_ff <= r_ent_in;
   end

   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_status = r_status_ff;
   assign rsp_result_slot = r_slot_ff;
   assign rsp_entry_msg_id = r_ent_ff.id;
   assign rsp_entry_sender = r_ent_ff.sender;
   assign rsp_entry_dest = r_ent_ff.dest;
   assign rsp_entry_state = r_ent_ff.st;
   assign rsp_entry_flags = r_ent_ff.flags;
   assign rsp_entry_incoming = r_ent_ff.inc;
   assign rsp_entry_read = r_ent_ff.rd;
   assign rsp_used_count = 5'(occ_ff);
   assign rsp_unread_total = unread_ff;

endmodule

/* rtl/mst_mem.sv */
// mst_mem: entry memory, one write port and one registered read port
// depends on mst_pkg
module mst_mem #(
   parameter int SLOTS = 16,
   parameter int AW = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  mst_pkg::entry_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output mst_pkg::entry_type  rd_data
);

   mst_pkg::entry_type mem [SLOTS];
   mst_pkg::entry_type rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sim/message_slot_table_with_aging_test.sv */
// testbench for message_slot_table_with_aging: random and directed table operations
// checked against an in-bench table predictor; depends on mst_pkg and the block rtl
module message_slot_table_with_aging_test;

   localparam int N_SLOTS = 16;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [3:0]  op;
      logic [31:0] now;
      logic [31:0] peer;
      logic [31:0] mid;
      logic [7:0]  flags;
      logic [3:0]  idx;
      logic [2:0]  ns;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  slot;
      logic [31:0] msg_id;
      logic [31:0] sender;
      logic [31:0] dest;
      logic [2:0]  state;
      logic [7:0]  flags;
      logic        inc;
      logic        rd;
      logic [4:0]  used;
      logic [4:0]  unread;
   } rsp_type;

   // table predictor plus queue of expected answers
   class table_scoreboard;
      mst_pkg::entry_type tbl[N_SLOTS];
      int unsigned used;
      logic [31:0] serial;
      logic [31:0] lifetime;
      logic [7:0]  retry_lim;
      logic [7:0]  burn_mask;
      rsp_type pending_answers[$];
      int errors;

      function new();
         lifetime = 32'd300000;
         retry_lim = 8'd3;
         burn_mask = 8'd1;
         serial = '0;
         used = 0;
         errors = 0;
         foreach (tbl[i]) tbl[i] = '0;
      endfunction

      function void write_reg(logic [1:0] index, logic [31:0] data);
         case (index)
            mst_pkg::CSR_EXPIRE: lifetime = data;
            mst_pkg::CSR_RETRY:  retry_lim = data[7:0];
            mst_pkg::CSR_BURN:   burn_mask = data[7:0];
            default: ;
         endcase
      endfunction

      function void report_entry(ref rsp_type r, input int i);
         r.slot = 4'(i);
         r.msg_id = tbl[i].id;
         r.sender = tbl[i].sender;
         r.dest = tbl[i].dest;
         r.state = tbl[i].st;
         r.flags = tbl[i].flags;
         r.inc = tbl[i].inc;
         r.rd = tbl[i].rd;
      endfunction

      function int victim_slot();
         int best;
         logic [31:0] best_ts;
         if (used < N_SLOTS) begin
            used++;
            return used - 1;
         end
         best = 0;
         best_ts = '1;
         for (int i = 0; i < N_SLOTS; i++) begin
            if (tbl[i].st == mst_pkg::ST_EXPIRED) return i;
            if (tbl[i].stamp < best_ts) begin
               best_ts = tbl[i].stamp;
               best = i;
            end
         end
         return best;
      endfunction

      // apply one accepted operation and queue its answer
      function void note_request(req_type q);
         rsp_type r;
         int i, w, cnt;
         logic [2:0] nsx;
         r = '0;
         case (q.op)
            mst_pkg::OP_ADD_IN, mst_pkg::OP_QUEUE: begin
               i = -1;
               if (q.op == mst_pkg::OP_ADD_IN)
                  for (int k = 0; k < used; k++)
                     if (i < 0 && tbl[k].id == q.mid && tbl[k].sender == q.peer) i = k;
               if (i >= 0) r.status = mst_pkg::RS_DUP;
               else begin
                  i = victim_slot();
                  tbl[i].stamp = q.now;
                  tbl[i].expiry = q.now + lifetime;
                  tbl[i].flags = q.flags;
                  if (q.op == mst_pkg::OP_ADD_IN) begin
                     tbl[i].id = q.mid;
                     tbl[i].sender = q.peer;
                     tbl[i].dest = '0;
                     tbl[i].st = mst_pkg::ST_DELIVERED;
                     tbl[i].inc = 1'b1;
                     tbl[i].rd = 1'b0;
                  end else begin
                     serial = serial + 32'd1;
                     tbl[i].id = serial;
                     tbl[i].sender = '0;
                     tbl[i].dest = q.peer;
                     tbl[i].st = mst_pkg::ST_QUEUED;
                     tbl[i].inc = 1'b0;
                     tbl[i].rd = 1'b1;
                  end
                  report_entry(r, i);
               end
            end
            mst_pkg::OP_SET, mst_pkg::OP_MARK, mst_pkg::OP_READ: begin
               if (q.idx >= used || (q.op == mst_pkg::OP_SET && q.ns > mst_pkg::ST_FAILED))
                  r.status = mst_pkg::RS_NONE;
               else begin
                  if (q.op == mst_pkg::OP_SET) tbl[q.idx].st = q.ns;
                  else if (q.op == mst_pkg::OP_MARK) tbl[q.idx].rd = 1'b1;
                  report_entry(r, q.idx);
               end
            end
            mst_pkg::OP_TICK: begin
               for (int k = 0; k < used; k++) begin
                  if (tbl[k].st != mst_pkg::ST_EXPIRED) begin
                     nsx = tbl[k].st;
                     if (q.now > tbl[k].expiry) nsx = mst_pkg::ST_EXPIRED;
                     else if ((tbl[k].flags & burn_mask) != 0 && tbl[k].rd && tbl[k].inc)
                        nsx = mst_pkg::ST_EXPIRED;
                     else if (!tbl[k].inc && tbl[k].st == mst_pkg::ST_QUEUED)
                        nsx = (retry_lim > 0) ? mst_pkg::ST_SENDING : mst_pkg::ST_FAILED;
                     tbl[k].st = nsx;
                  end
               end
            end
            mst_pkg::OP_PENDING: begin
               i = -1;
               for (int k = 0; k < used; k++)
                  if (i < 0 && !tbl[k].inc && tbl[k].st == mst_pkg::ST_SENDING) i = k;
               if (i >= 0) report_entry(r, i);
               else r.status = mst_pkg::RS_NONE;
            end
            mst_pkg::OP_PURGE: begin
               w = 0;
               for (int k = 0; k < used; k++)
                  if (tbl[k].st != mst_pkg::ST_EXPIRED) begin
                     tbl[w] = tbl[k];
                     w++;
                  end
               for (int k = w; k < N_SLOTS; k++) tbl[k] = '0;
               used = w;
            end
            mst_pkg::OP_CLEAR: begin
               foreach (tbl[k]) tbl[k] = '0;
               used = 0;
            end
            default: ;
         endcase
         cnt = 0;
         for (int k = 0; k < used; k++)
            if (tbl[k].inc && !tbl[k].rd && tbl[k].st != mst_pkg::ST_EXPIRED) cnt++;
         r.used = 5'(used);
         r.unread = 5'(cnt);
         pending_answers.push_back(r);
      endfunction

      function void check_answer(rsp_type a);
         rsp_type e;
         if (pending_answers.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
            return;
         end
         e = pending_answers.pop_front();
         if (a.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, a.status); errors++; end
         if (a.slot !== e.slot) begin
            $error("result_slot exp %0d got %0d", e.slot, a.slot); errors++; end
         if (a.msg_id !== e.msg_id) begin
            $error("entry_msg_id exp %h got %h", e.msg_id, a.msg_id); errors++; end
         if (a.sender !== e.sender) begin
            $error("entry_sender exp %h got %h", e.sender, a.sender); errors++; end
         if (a.dest !== e.dest) begin
            $error("entry_dest exp %h got %h", e.dest, a.dest); errors++; end
         if (a.state !== e.state) begin
            $error("entry_state exp %0d got %0d", e.state, a.state); errors++; end
         if (a.flags !== e.flags) begin
            $error("entry_flags exp %h got %h", e.flags, a.flags); errors++; end
         if (a.inc !== e.inc) begin
            $error("entry_incoming exp %0d got %0d", e.inc, a.inc); errors++; end
         if (a.rd !== e.rd) begin
            $error("entry_read exp %0d got %0d", e.rd, a.rd); errors++; end
         if (a.used !== e.used) begin
            $error("used_count exp %0d got %0d", e.used, a.used); errors++; end
         if (a.unread !== e.unread) begin
            $error("unread_total exp %0d got %0d", e.unread, a.unread); errors++; end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [3:0]  req_operation = 0;
   logic [31:0] req_now_ms = 0;
   logic [31:0] req_peer_id = 0;
   logic [31:0] req_message_id = 0;
   logic [7:0]  req_message_flags = 0;
   logic [3:0]  req_slot_index = 0;
   logic [2:0]  req_new_state = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_result_slot;
   logic [31:0] rsp_entry_msg_id;
   logic [31:0] rsp_entry_sender;
   logic [31:0] rsp_entry_dest;
   logic [2:0]  rsp_entry_state;
   logic [7:0]  rsp_entry_flags;
   logic        rsp_entry_incoming;
   logic        rsp_entry_read;
   logic [4:0]  rsp_used_count;
   logic [4:0]  rsp_unread_total;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = 0;
   logic [31:0] csr_data = 0;

   message_slot_table_with_aging #(.SLOTS(N_SLOTS)) uut (.*);

   table_scoreboard sb = new();
   int sender_idle_pct = 27;
   int receiver_idle_pct = 56;
   bit hold_receiver = 0;
   int idle_cycles = 0;
   logic [31:0] clock_ms = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // result side: random back-pressure, sampling at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_answer({rsp_status, rsp_result_slot, rsp_entry_msg_id, rsp_entry_sender,
                          rsp_entry_dest, rsp_entry_state, rsp_entry_flags,
                          rsp_entry_incoming, rsp_entry_read, rsp_used_count,
                          rsp_unread_total});
   end

   always @(negedge clock) begin
      rsp_ready <= !hold_receiver && ($urandom_range(99) >= receiver_idle_pct);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_item(req_type q);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) @(negedge clock);
      req_valid <= 1;
      req_operation <= q.op;
      req_now_ms <= q.now;
      req_peer_id <= q.peer;
      req_message_id <= q.mid;
      req_message_flags <= q.flags;
      req_slot_index <= q.idx;
      req_new_state <= q.ns;
      do @(posedge clock); while (!req_ready);
      sb.note_request(q);
      @(negedge clock);
      req_valid <= 0;
   endtask

   task automatic wait_drained();
      while (sb.pending_answers.size() != 0) @(negedge clock);
      repeat (3 * N_SLOTS + 10) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, data);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic req_type make_item(logic [3:0] op);
      req_type q;
      q.op = op;
      q.now = clock_ms;
      q.peer = $urandom_range(3);
      q.mid = $urandom_range(7);
      if ($urandom_range(9) == 0) begin
         q.peer = $urandom();
         q.mid = $urandom();
      end
      q.flags = 8'($urandom());
      q.idx = 4'($urandom_range(15));
      q.ns = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
      return q;
   endfunction

   // mostly table-building traffic with aging, plus noise
   function automatic logic [3:0] pick_op();
      int p;
      p = $urandom_range(99);
      if (p < 30) return mst_pkg::OP_ADD_IN;
      if (p < 45) return mst_pkg::OP_QUEUE;
      if (p < 52) return mst_pkg::OP_SET;
      if (p < 60) return mst_pkg::OP_MARK;
      if (p < 68) return mst_pkg::OP_READ;
      if (p < 80) return mst_pkg::OP_TICK;
      if (p < 88) return mst_pkg::OP_PENDING;
      if (p < 93) return mst_pkg::OP_PURGE;
      if (p < 96) return mst_pkg::OP_CLEAR;
      return 4'($urandom_range(15, 9));
   endfunction

   task automatic random_phase(int count);
      req_type q;
      for (int n = 0; n < count; n++) begin
         clock_ms = clock_ms + $urandom_range(2000);
         if ($urandom_range(49) == 0) clock_ms = $urandom();
         q = make_item(pick_op());
         send_item(q);
      end
   endtask

   initial begin
      req_type q;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: field extremes, every operation, duplicates, bad slots and states
      q = make_item(mst_pkg::OP_ADD_IN); q.now = 0; q.peer = '1; q.mid = '1; q.flags = '1;
      send_item(q);
      send_item(q);
      q.peer = 0; q.mid = 0; q.flags = 0; send_item(q);
      q = make_item(mst_pkg::OP_QUEUE); q.peer = '1; q.now = 32'hffff_fff0; send_item(q);
      q = make_item(mst_pkg::OP_MARK); q.idx = 0; send_item(q);
      q = make_item(mst_pkg::OP_READ); q.idx = 15; send_item(q);
      q = make_item(mst_pkg::OP_SET); q.idx = 1; q.ns = 7; send_item(q);
      q.ns = mst_pkg::ST_FAILED; send_item(q);
      q = make_item(mst_pkg::OP_PENDING); send_item(q);
      q = make_item(mst_pkg::OP_TICK); q.now = 100; send_item(q);
      q = make_item(mst_pkg::OP_PENDING); send_item(q);
      q = make_item(mst_pkg::OP_TICK); q.now = '1; send_item(q);
      q = make_item(mst_pkg::OP_PURGE); send_item(q);
      for (int k = 0; k < 18; k++) begin
         q = make_item(k[0] ? mst_pkg::OP_QUEUE : mst_pkg::OP_ADD_IN);
         q.mid = k + 100; q.now = 18 - k;
         send_item(q);
      end
      q = make_item(mst_pkg::OP_CLEAR); send_item(q);
      q = make_item(4'd15); send_item(q);
      wait_drained();

      // register settings, extremes included
      write_csr(mst_pkg::CSR_EXPIRE, '1);
      write_csr(mst_pkg::CSR_RETRY, 32'd0);
      write_csr(mst_pkg::CSR_BURN, 32'hff);
      random_phase(150);

      // receiver stalled long while the sender keeps offering
      fork
         begin
            hold_receiver = 1;
            repeat (400) @(negedge clock);
            hold_receiver = 0;
         end
         random_phase(20);
      join
      wait_drained();
      write_csr(mst_pkg::CSR_EXPIRE, 32'd0);
      write_csr(mst_pkg::CSR_RETRY, 32'hff);
      write_csr(mst_pkg::CSR_BURN, 32'd0);
      sender_idle_pct = 56;
      receiver_idle_pct = 27;
      random_phase(200);
      wait_drained();
      write_csr(mst_pkg::CSR_EXPIRE, 32'd5000);
      write_csr(mst_pkg::CSR_RETRY, 32'd3);
      write_csr(mst_pkg::CSR_BURN, 32'h81);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      random_phase(230);
      wait_drained();

      if (sb.errors == 0 && sb.pending_answers.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
